// File: src/cnt_pkg.sv
`default_nettype none

package cnt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int KEY_W           = 64;
  localparam int INDEX_W         = 4;
  localparam int LIST_LIMIT      = 16;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_LIST
  } fsm_t;

endpackage

`default_nettype wire

// File: src/compacting_name_table.sv
// Dense, ordered table of name keys held in one synchronous RAM plus an
// entry count. A command is transferred on a rising edge with start high
// and busy low; action selects create, delete or list, and key carries the
// name (bytes above KEY_BYTES are cleared). Results come out one per cycle
// on status, entry_key, entry_index and last, each marked by strobe for
// exactly one cycle; the receiver has no way to hold them off.
// Create scans the valid entries through the RAM read port, one entry per
// cycle, and stops at a match. Delete scans the same way, then, if the key
// is found, moves every later entry down one slot: each is read and then
// written one slot lower, with at most one read and one write per cycle.
// List streams the first min(count, 16) entries one per cycle; an empty
// table gives one empty status in the cycle after the command. A new
// command can be transferred in the cycle the final result is shown.
// Reset clears the entry count and the controller; the RAM contents are
// not touched and are never read above the count.
`default_nettype none

module compacting_name_table #(
  parameter int MAX_ENTRIES = cnt_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BYTES   = cnt_pkg::KEY_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  action,
  input  wire logic [cnt_pkg::KEY_W-1:0]   key,
  output logic                             strobe,
  output logic [2:0]                       status,
  output logic [cnt_pkg::KEY_W-1:0]        entry_key,
  output logic [cnt_pkg::INDEX_W-1:0]      entry_index,
  output logic                             last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LIST_CAP = (MAX_ENTRIES < cnt_pkg::LIST_LIMIT) ?
                            MAX_ENTRIES : cnt_pkg::LIST_LIMIT;
  localparam logic [cnt_pkg::KEY_W-1:0] KEY_MASK =
    {cnt_pkg::KEY_W{1'b1}} >> (cnt_pkg::KEY_W - 8 * KEY_BYTES);

  logic [cnt_pkg::KEY_W-1:0] mem [MAX_ENTRIES];
  logic [cnt_pkg::KEY_W-1:0] rdata;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_raddr;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [cnt_pkg::KEY_W-1:0] mem_wdata;

  cnt_pkg::fsm_t             state, state_next;
  cnt_pkg::action_t          act, act_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [CNT_W-1:0]          ptr, ptr_next;
  logic                      rd_pend, rd_pend_next;
  logic [IDX_W-1:0]          rd_addr, rd_addr_next;
  logic [IDX_W-1:0]          hit_idx, hit_idx_next;
  logic [cnt_pkg::KEY_W-1:0] key_r, key_r_next;

  logic                      strobe_next;
  cnt_pkg::status_t          status_next;
  logic [cnt_pkg::KEY_W-1:0] entry_key_next;
  logic [cnt_pkg::INDEX_W-1:0] entry_index_next;
  logic                      last_next;

  logic                      hit;
  logic [CNT_W-1:0]          list_total;

  // Reads are issued only below the count, so unwritten slots are never used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign hit = rd_pend && (rdata == key_r);
  assign list_total = (count < CNT_W'(LIST_CAP)) ? count : CNT_W'(LIST_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cnt_pkg::S_IDLE;
      count   <= '0;
      ptr     <= '0;
      rd_pend <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ptr     <= ptr_next;
      rd_pend <= rd_pend_next;
      strobe  <= strobe_next;
    end
    act         <= act_next;
    rd_addr     <= rd_addr_next;
    hit_idx     <= hit_idx_next;
    key_r       <= key_r_next;
    status      <= status_next;
    entry_key   <= entry_key_next;
    entry_index <= entry_index_next;
    last        <= last_next;
  end

  always_comb begin
    state_next       = state;
    act_next         = act;
    count_next       = count;
    ptr_next         = ptr;
    rd_pend_next     = rd_pend;
    rd_addr_next     = rd_addr;
    hit_idx_next     = hit_idx;
    key_r_next       = key_r;
    strobe_next      = 1'b0;
    status_next      = cnt_pkg::status_t'(status);
    entry_key_next   = entry_key;
    entry_index_next = entry_index;
    last_next        = last;
    mem_re           = 1'b0;
    mem_raddr        = ptr[IDX_W-1:0];
    mem_we           = 1'b0;
    mem_waddr        = count[IDX_W-1:0];
    mem_wdata        = key_r;
    busy             = (state != cnt_pkg::S_IDLE);

    unique case (state)
      cnt_pkg::S_IDLE: begin
        if (start) begin
          act_next     = cnt_pkg::action_t'(action);
          key_r_next   = key & KEY_MASK;
          ptr_next     = '0;
          rd_pend_next = 1'b0;
          unique case (cnt_pkg::action_t'(action))
            cnt_pkg::ACT_CREATE, cnt_pkg::ACT_DELETE: begin
              state_next = cnt_pkg::S_SEARCH;
            end
            cnt_pkg::ACT_LIST: begin
              if (count == '0) begin
                strobe_next      = 1'b1;
                status_next      = cnt_pkg::ST_EMPTY;
                entry_key_next   = key & KEY_MASK;
                entry_index_next = '0;
                last_next        = 1'b1;
              end else begin
                state_next = cnt_pkg::S_LIST;
              end
            end
            default: begin
              state_next = cnt_pkg::S_IDLE;
            end
          endcase
        end
      end

      cnt_pkg::S_SEARCH: begin
        entry_key_next = key_r;
        last_next      = 1'b1;
        if (hit) begin
          if (act == cnt_pkg::ACT_CREATE) begin
            strobe_next      = 1'b1;
            status_next      = cnt_pkg::ST_EXISTS;
            entry_index_next = cnt_pkg::INDEX_W'(rd_addr);
            state_next       = cnt_pkg::S_IDLE;
          end else begin
            hit_idx_next = rd_addr;
            ptr_next     = CNT_W'(rd_addr) + 1'b1;
            rd_pend_next = 1'b0;
            state_next   = cnt_pkg::S_SHIFT;
          end
        end else if (ptr < count) begin
          mem_re       = 1'b1;
          rd_pend_next = 1'b1;
          rd_addr_next = ptr[IDX_W-1:0];
          ptr_next     = ptr + 1'b1;
        end else begin
          // Scan exhausted without a match.
          strobe_next  = 1'b1;
          rd_pend_next = 1'b0;
          state_next   = cnt_pkg::S_IDLE;
          if (act == cnt_pkg::ACT_DELETE) begin
            status_next      = cnt_pkg::ST_NOT_FOUND;
            entry_index_next = '0;
          end else if (count == CNT_W'(MAX_ENTRIES)) begin
            status_next      = cnt_pkg::ST_FULL;
            entry_index_next = '0;
          end else begin
            mem_we           = 1'b1;
            count_next       = count + 1'b1;
            status_next      = cnt_pkg::ST_CREATED;
            entry_index_next = cnt_pkg::INDEX_W'(count);
          end
        end
      end

      cnt_pkg::S_SHIFT: begin
        // Slot j+2 is read while slot j is written with slot j+1's data, so the
        // read always runs two slots ahead of the write and never sees stale data.
        if (rd_pend) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr - 1'b1;
          mem_wdata = rdata;
        end
        if (ptr < count) begin
          mem_re       = 1'b1;
          rd_pend_next = 1'b1;
          rd_addr_next = ptr[IDX_W-1:0];
          ptr_next     = ptr + 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            count_next       = count - 1'b1;
            strobe_next      = 1'b1;
            status_next      = cnt_pkg::ST_DELETED;
            entry_key_next   = key_r;
            entry_index_next = cnt_pkg::INDEX_W'(hit_idx);
            last_next        = 1'b1;
            state_next       = cnt_pkg::S_IDLE;
          end
        end
      end

      cnt_pkg::S_LIST: begin
        if (rd_pend) begin
          strobe_next      = 1'b1;
          status_next      = cnt_pkg::ST_LISTED;
          entry_key_next   = rdata;
          entry_index_next = cnt_pkg::INDEX_W'(rd_addr);
          last_next        = (CNT_W'(rd_addr) + 1'b1 == list_total);
        end
        if (ptr < list_total) begin
          mem_re       = 1'b1;
          rd_pend_next = 1'b1;
          rd_addr_next = ptr[IDX_W-1:0];
          ptr_next     = ptr + 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          ptr_next     = '0;
          state_next   = cnt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = cnt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

module tb_top;

  localparam int MAX_ENTRIES = cnt_pkg::MAX_ENTRIES_DEF;
  localparam logic [cnt_pkg::KEY_W-1:0] KEY_MASK =
    {cnt_pkg::KEY_W{1'b1}} >> (64 - 8 * cnt_pkg::KEY_BYTES_DEF);
  localparam int RANDOM_ITEMS = 370;
  localparam int POOL_SIZE = 22;
  localparam int TAIL_ITEMS = 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    cnt_pkg::action_t                op;
    logic [cnt_pkg::KEY_W-1:0]       name;
  } table_cmd_t;

  typedef struct {
    cnt_pkg::status_t                status;
    logic [cnt_pkg::KEY_W-1:0]       entry_key;
    logic [cnt_pkg::INDEX_W-1:0]     entry_index;
    logic                            last;
  } table_response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] action = cnt_pkg::ACT_CREATE;
  logic [cnt_pkg::KEY_W-1:0] key = '0;
  logic busy;
  logic strobe;
  logic [2:0] status;
  logic [cnt_pkg::KEY_W-1:0] entry_key;
  logic [cnt_pkg::INDEX_W-1:0] entry_index;
  logic last;

  table_cmd_t command_queue[$];
  table_response_t pending_responses[$];
  logic [cnt_pkg::KEY_W-1:0] shadow_names[MAX_ENTRIES];
  int shadow_count = 0;
  int total_cmds = 0;
  int transfers_done = 0;
  int gap_left = 0;
  bit idle_mode = 1'b1;
  int failures = 0;
  int quiet_cycles = 0;
  table_cmd_t next_cmd;

  compacting_name_table u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .key         (key),
    .strobe      (strobe),
    .status      (status),
    .entry_key   (entry_key),
    .entry_index (entry_index),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [cnt_pkg::KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_cmd(cnt_pkg::action_t op, logic [cnt_pkg::KEY_W-1:0] name);
    table_cmd_t c;
    c.op = op;
    c.name = name;
    command_queue.push_back(c);
    total_cmds++;
  endtask

  task automatic add_response(cnt_pkg::status_t s, logic [cnt_pkg::KEY_W-1:0] k, int idx,
                              logic lst);
    table_response_t r;
    r.status = s;
    r.entry_key = k;
    r.entry_index = idx[cnt_pkg::INDEX_W-1:0];
    r.last = lst;
    pending_responses.push_back(r);
  endtask

  // Applies one command to the shadow table and queues the responses it causes.
  task automatic predict_table_op(cnt_pkg::action_t op, logic [cnt_pkg::KEY_W-1:0] raw_key);
    logic [cnt_pkg::KEY_W-1:0] k;
    int hit;
    int total;
    k = raw_key & KEY_MASK;
    hit = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_names[i] == k) hit = i;
    end
    case (op)
      cnt_pkg::ACT_CREATE: begin
        if (hit >= 0) begin
          add_response(cnt_pkg::ST_EXISTS, k, hit, 1'b1);
        end else if (shadow_count >= MAX_ENTRIES) begin
          add_response(cnt_pkg::ST_FULL, k, 0, 1'b1);
        end else begin
          shadow_names[shadow_count] = k;
          add_response(cnt_pkg::ST_CREATED, k, shadow_count, 1'b1);
          shadow_count++;
        end
      end
      cnt_pkg::ACT_DELETE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < shadow_count; i++) shadow_names[i] = shadow_names[i + 1];
          shadow_count--;
          add_response(cnt_pkg::ST_DELETED, k, hit, 1'b1);
        end else begin
          add_response(cnt_pkg::ST_NOT_FOUND, k, 0, 1'b1);
        end
      end
      cnt_pkg::ACT_LIST: begin
        total = (shadow_count > cnt_pkg::LIST_LIMIT) ? cnt_pkg::LIST_LIMIT : shadow_count;
        if (total == 0) begin
          add_response(cnt_pkg::ST_EMPTY, k, 0, 1'b1);
        end else begin
          for (int i = 0; i < total; i++) begin
            add_response(cnt_pkg::ST_LISTED, shadow_names[i], i, (i == total - 1));
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: presents queued commands, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      action <= cnt_pkg::ACT_CREATE;
      key <= '0;
    end else begin
      if (start && !busy) begin
        predict_table_op(cnt_pkg::action_t'(action), key);
        transfers_done++;
        if ($urandom_range(0, 39) == 0) idle_mode = !idle_mode;
        if (idle_mode && command_queue.size() > TAIL_ITEMS && $urandom_range(0, 2) == 0) begin
          gap_left = $urandom_range(1, 13);
        end
      end
      if (!start || busy == 1'b0) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
          action <= 2'($urandom_range(0, 3));
          key <= rand_key();
        end else if (command_queue.size() > 0) begin
          next_cmd = command_queue.pop_front();
          start <= 1'b1;
          action <= next_cmd.op;
          key <= next_cmd.name;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    table_response_t exp_r;
    if (!rst && strobe) begin
      if (pending_responses.size() == 0) begin
        $error("unexpected result: status %0d, entry_key %h", status, entry_key);
        failures++;
      end else begin
        exp_r = pending_responses.pop_front();
        if (status !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, status);
          failures++;
        end
        if (entry_key !== exp_r.entry_key) begin
          $error("entry_key mismatch: expected %h, got %h", exp_r.entry_key, entry_key);
          failures++;
        end
        if (entry_index !== exp_r.entry_index) begin
          $error("entry_index mismatch: expected %0d, got %0d", exp_r.entry_index,
                 entry_index);
          failures++;
        end
        if (last !== exp_r.last) begin
          $error("last mismatch: expected %0d, got %0d", exp_r.last, last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [cnt_pkg::KEY_W-1:0] name_pool[POOL_SIZE];
    logic [cnt_pkg::KEY_W-1:0] fill_key;
    int pick;
    int counted;
    bit create_phase;

    // Directed part: empty table, zero and all-ones names, duplicates,
    // a full table, a full list and deletes at the front of the table.
    queue_cmd(cnt_pkg::ACT_LIST, rand_key());
    queue_cmd(cnt_pkg::ACT_DELETE, rand_key());
    queue_cmd(cnt_pkg::ACT_NONE, rand_key());
    queue_cmd(cnt_pkg::ACT_CREATE, '0);
    queue_cmd(cnt_pkg::ACT_CREATE, {cnt_pkg::KEY_W{1'b1}});
    queue_cmd(cnt_pkg::ACT_CREATE, '0);
    for (int i = 2; i < MAX_ENTRIES; i++) begin
      queue_cmd(cnt_pkg::ACT_CREATE, {$urandom(), 28'h0, i[3:0]});
    end
    fill_key = {$urandom(), 32'h0};
    queue_cmd(cnt_pkg::ACT_CREATE, fill_key);
    queue_cmd(cnt_pkg::ACT_LIST, rand_key());
    queue_cmd(cnt_pkg::ACT_DELETE, '0);
    queue_cmd(cnt_pkg::ACT_DELETE, {cnt_pkg::KEY_W{1'b1}});
    queue_cmd(cnt_pkg::ACT_CREATE, fill_key);
    queue_cmd(cnt_pkg::ACT_LIST, rand_key());

    // The pool holds more names than the table has slots, so random
    // sequences hit duplicates, deletes of present names and a full table.
    name_pool[0] = '0;
    name_pool[1] = {cnt_pkg::KEY_W{1'b1}};
    for (int i = 2; i < POOL_SIZE; i++) begin
      name_pool[i] = rand_key() & ({cnt_pkg::KEY_W{1'b1}} >> (8 * $urandom_range(0, 7)));
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      create_phase = ((counted / 40) % 2) == 0;
      pick = $urandom_range(0, 99);
      fill_key = ($urandom_range(0, 9) < 8) ? name_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : rand_key();
      if (pick < 4) begin
        queue_cmd(cnt_pkg::ACT_NONE, fill_key);
      end else begin
        if (pick < (create_phase ? 60 : 30)) begin
          queue_cmd(cnt_pkg::ACT_CREATE, fill_key);
        end else if (pick < (create_phase ? 82 : 80)) begin
          queue_cmd(cnt_pkg::ACT_DELETE, fill_key);
        end else begin
          queue_cmd(cnt_pkg::ACT_LIST, fill_key);
        end
        counted++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (transfers_done < total_cmds) @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
